[src/rsmp_pkg.sv]
// Shared constants and types of the linear interpolation resampler.
`timescale 1ns / 1ps
package rsmp_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int FRAC_BITS     = 20;
	localparam int MAX_UPSAMPLE  = 16;
	localparam int STEP_BITS     = FRAC_BITS + 4;
	localparam int POS_BITS      = FRAC_BITS + 6;
	localparam int CNT_BITS      = $clog2(MAX_UPSAMPLE + 1);
	localparam int BIT_CNT_BITS  = $clog2(FRAC_BITS);
	localparam int ACC_BITS      = SAMPLE_BITS + 2;
	localparam int SUM_BITS      = SAMPLE_BITS + 3;
	localparam int STEP_MIN_INT  = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;

	localparam logic [POS_BITS-1:0]    ONE_POS    = POS_BITS'(1) << FRAC_BITS;
	localparam logic [STEP_BITS-1:0]   STEP_RESET = STEP_BITS'(1) << FRAC_BITS;
	localparam logic [STEP_BITS-1:0]   STEP_MIN   = STEP_BITS'(STEP_MIN_INT);
	localparam logic [SAMPLE_BITS-1:0] SIGN_BIT   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [CNT_BITS-1:0]    CNT_MAX    = CNT_BITS'(MAX_UPSAMPLE);
	localparam logic [BIT_CNT_BITS-1:0] BIT_LAST  = BIT_CNT_BITS'(FRAC_BITS - 1);

	typedef struct packed {
		logic                   start;
		logic [SAMPLE_BITS-1:0] a;
		logic [SAMPLE_BITS-1:0] b;
		logic [FRAC_BITS-1:0]   frac;
	} rsmp_mul_req_t;

	typedef struct packed {
		logic                   done;
		logic [SAMPLE_BITS-1:0] result;
	} rsmp_mul_rsp_t;

endpackage

[src/rsmp_in_if.sv]
// Input channel interface carrying one audio sample item.
`timescale 1ns / 1ps
interface rsmp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_in;
	logic                                  end_of_stream;

	modport source (output valid, output sample_in, output end_of_stream, input ready);
	modport sink (input valid, input sample_in, input end_of_stream, output ready);
endinterface

[src/rsmp_out_if.sv]
// Output channel interface carrying one resampled item.
`timescale 1ns / 1ps
interface rsmp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_out;
	logic                                  last_of_run;
	logic                                  stream_done;

	modport source (output valid, output sample_out, output last_of_run, output stream_done,
		input ready);
	modport sink (input valid, input sample_out, input last_of_run, input stream_done,
		output ready);
endinterface

[src/linear_interp_resampler.sv]
// Top level of the linear interpolation resampler: sequencer, state and output register.
//
// Usage: samples enter on in_ch, one item per input sample with end_of_stream set on the
// final sample of a stream. Results leave on out_ch, zero to sixteen per input item
// (up to thirty-two on the final sample), in order, with last_of_run on the final result
// of each input and stream_done on the final result of the stream. The step_ratio
// register holds source rate over target rate in Q4.20 and is written with
// step_ratio_we; it is sampled when an input item is accepted.
// Each interpolated result passes through a bit-serial multiplier that takes one fraction
// bit per cycle, and a held copy of the final sample bypasses the multiplier; in_ch.ready
// is high only between items.
// Reset clears the held sample and the output position and sets the step to 1.0;
// the first sample of a stream only primes the held sample. When the receiver stalls,
// the output register keeps its item and the sequencer waits for it to drain.
`timescale 1ns / 1ps
module linear_interp_resampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step_ratio_we,
	input  logic [rsmp_pkg::STEP_BITS-1:0]    step_ratio,
	rsmp_in_if.sink                           in_ch,
	rsmp_out_if.source                        out_ch
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK1,
		S_MUL,
		S_PUT,
		S_END1,
		S_CHECK2
	} state_t;

	state_t                              state_q;
	logic [rsmp_pkg::STEP_BITS-1:0]      step_cfg_q;
	logic [rsmp_pkg::STEP_BITS-1:0]      step_q;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]    cur_q;
	logic                                eos_q;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]    held_q;
	logic                                have_held_q;
	logic [rsmp_pkg::POS_BITS-1:0]       next_pos_q;
	logic [rsmp_pkg::POS_BITS-1:0]       pos_q;
	logic [rsmp_pkg::CNT_BITS-1:0]       cnt_q;
	logic                                ph2_q;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]    res_q;
	logic                                out_valid_q;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]    out_sample_q;
	logic                                out_last_q;
	logic                                out_done_q;

	logic [rsmp_pkg::STEP_BITS-1:0]      step_eff;
	logic [rsmp_pkg::POS_BITS-1:0]       pos_add;
	logic [rsmp_pkg::POS_BITS-1:0]       pos_wrap;
	logic                                more_here;
	logic                                is_last;
	logic                                out_free;
	rsmp_pkg::rsmp_mul_req_t             mul_req;
	rsmp_pkg::rsmp_mul_rsp_t             mul_rsp;

	always_comb begin
		step_eff  = (step_cfg_q < rsmp_pkg::STEP_MIN) ? rsmp_pkg::STEP_MIN : step_cfg_q;
		pos_add   = pos_q + rsmp_pkg::POS_BITS'(step_q);
		pos_wrap  = (pos_q >= rsmp_pkg::ONE_POS) ? pos_q - rsmp_pkg::ONE_POS : '0;
		more_here = (cnt_q < rsmp_pkg::CNT_MAX) && (pos_q < rsmp_pkg::ONE_POS);
		if (ph2_q) begin
			is_last = !more_here;
		end else begin
			is_last = !more_here && (!eos_q || (pos_wrap >= rsmp_pkg::ONE_POS));
		end
		out_free = !out_valid_q || out_ch.ready;
	end

	assign mul_req.start = (state_q == S_CHECK1) && more_here;
	assign mul_req.a     = held_q;
	assign mul_req.b     = cur_q;
	assign mul_req.frac  = pos_q[rsmp_pkg::FRAC_BITS-1:0];

	rsmp_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_cfg_q   <= rsmp_pkg::STEP_RESET;
			step_q       <= rsmp_pkg::STEP_RESET;
			cur_q        <= '0;
			eos_q        <= 1'b0;
			held_q       <= '0;
			have_held_q  <= 1'b0;
			next_pos_q   <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			ph2_q        <= 1'b0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_last_q   <= 1'b0;
			out_done_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && (state_q != S_PUT)) begin
				out_valid_q <= 1'b0;
			end
			if (step_ratio_we) begin
				step_cfg_q <= step_ratio;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cur_q   <= in_ch.sample_in;
						eos_q   <= in_ch.end_of_stream;
						step_q  <= step_eff;
						pos_q   <= next_pos_q;
						cnt_q   <= '0;
						ph2_q   <= 1'b0;
						state_q <= have_held_q ? S_CHECK1 : S_END1;
					end
				end
				S_CHECK1: begin
					state_q <= more_here ? S_MUL : S_END1;
				end
				S_MUL: begin
					if (mul_rsp.done) begin
						res_q   <= mul_rsp.result;
						pos_q   <= pos_add;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= res_q;
						out_last_q   <= is_last;
						out_done_q   <= is_last && eos_q;
						state_q      <= ph2_q ? S_CHECK2 : S_CHECK1;
					end
				end
				S_END1: begin
					pos_q <= pos_wrap;
					cnt_q <= '0;
					ph2_q <= 1'b1;
					if (eos_q) begin
						state_q <= S_CHECK2;
					end else begin
						held_q      <= cur_q;
						have_held_q <= 1'b1;
						next_pos_q  <= pos_wrap;
						state_q     <= S_IDLE;
					end
				end
				S_CHECK2: begin
					if (more_here) begin
						res_q   <= cur_q;
						pos_q   <= pos_add;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_PUT;
					end else begin
						held_q      <= '0;
						have_held_q <= 1'b0;
						next_pos_q  <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.sample_out  = out_sample_q;
	assign out_ch.last_of_run = out_last_q;
	assign out_ch.stream_done = out_done_q;

endmodule

[src/rsmp_interp.sv]
// Bit-serial interpolator that forms a + (b - a) * frac one fraction bit per cycle.
`timescale 1ns / 1ps
module rsmp_interp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rsmp_pkg::rsmp_mul_req_t req,
	output rsmp_pkg::rsmp_mul_rsp_t rsp
);

	logic                                   busy_q;
	logic [rsmp_pkg::BIT_CNT_BITS-1:0]      bit_q;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]       a_q;
	logic signed [rsmp_pkg::SAMPLE_BITS:0]  diff_q;
	logic [rsmp_pkg::FRAC_BITS-1:0]         frac_q;
	logic signed [rsmp_pkg::ACC_BITS-1:0]   acc_q;
	logic                                   done_q;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]       result_q;

	logic [rsmp_pkg::SAMPLE_BITS-1:0]       a_off;
	logic [rsmp_pkg::SAMPLE_BITS-1:0]       b_off;
	logic                                   last_bit;
	logic signed [rsmp_pkg::SUM_BITS-1:0]   addend;
	logic signed [rsmp_pkg::SUM_BITS-1:0]   sum;
	logic signed [rsmp_pkg::ACC_BITS-1:0]   acc_next;
	logic signed [rsmp_pkg::ACC_BITS-1:0]   total;

	assign a_off    = req.a ^ rsmp_pkg::SIGN_BIT;
	assign b_off    = req.b ^ rsmp_pkg::SIGN_BIT;
	assign last_bit = (bit_q == rsmp_pkg::BIT_LAST);

	// The rounding half is injected as a carry on the last bit, where it weighs 2^(FRAC-1).
	always_comb begin
		addend   = frac_q[0] ? rsmp_pkg::SUM_BITS'(diff_q) : '0;
		sum      = rsmp_pkg::SUM_BITS'(acc_q) + addend
			+ (last_bit ? rsmp_pkg::SUM_BITS'(1) : rsmp_pkg::SUM_BITS'(0));
		acc_next = rsmp_pkg::ACC_BITS'(sum >>> 1);
		total    = $signed({2'b00, a_q}) + acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			bit_q    <= '0;
			a_q      <= '0;
			diff_q   <= '0;
			frac_q   <= '0;
			acc_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && last_bit;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				a_q    <= a_off;
				diff_q <= $signed({1'b0, b_off}) - $signed({1'b0, a_off});
				frac_q <= req.frac;
				acc_q  <= '0;
			end else if (busy_q) begin
				acc_q  <= acc_next;
				frac_q <= frac_q >> 1;
				bit_q  <= bit_q + 1'b1;
				if (last_bit) begin
					busy_q   <= 1'b0;
					result_q <= total[rsmp_pkg::SAMPLE_BITS-1:0] ^ rsmp_pkg::SIGN_BIT;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

[src/rsmp_checker.sv]
// Port-level assertions of the resampler and their binding to the top level.
`timescale 1ns / 1ps
module rsmp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rsmp_pkg::SAMPLE_BITS-1:0]  sample_out,
	input logic                              last_of_run,
	input logic                              stream_done
);

	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out)
			&& $stable(last_of_run) && $stable(stream_done))
		else $error("stalled output item changed");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_run)
		else $error("stream_done without last_of_run");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in two consecutive cycles");

endmodule

bind linear_interp_resampler rsmp_checker u_rsmp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.sample_out  (out_ch.sample_out),
	.last_of_run (out_ch.last_of_run),
	.stream_done (out_ch.stream_done)
);
